>>> rtl/mkcd_pkg.sv
// ----------------------------------------------------------------------------
// mkcd_pkg
// Shared widths and defaults for the multi-key counter debouncer.
// ----------------------------------------------------------------------------
package mkcd_pkg;

   // number of sampled key lines carried by one input word
   localparam int LINE_BITS    = 4;
   // debounce counter and threshold width
   localparam int CNT_W        = 8;
   // press event code width
   localparam int EVT_W        = 3;
   // stream data widths, padded to whole bytes
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 8;

   // default key count and threshold after reset
   localparam int              NUM_KEYS_DEF  = 4;
   localparam logic [CNT_W-1:0] THRESHOLD_RST = CNT_W'(16);

endpackage

>>> rtl/multi_key_counter_debouncer_top.sv
// ----------------------------------------------------------------------------
// multi_key_counter_debouncer_top
// Debounces active-low key lines with one counter lane per key and reports
// the recognized press event for each sample word.
// ----------------------------------------------------------------------------
// output: the event word appears on rsp in the cycle after its sample is taken
// throughput: one sample word per cycle; lane counters update in the accept cycle
// and the single output register frees whenever the downstream takes its word
// reset: synchronous, clears all counters and handled flags, empties the output
// register and loads the press threshold with 16
module multi_key_counter_debouncer_top
   import mkcd_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // sample channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [3:0] key_levels_n
   // event channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [2:0] press_event
   // threshold register
   input  logic                   csr_wen,
   input  logic [CNT_W-1:0]       csr_wdata
);

   logic [CNT_W-1:0]    threshold_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [EVT_W-1:0]    rsp_event_ff;
   logic [EVT_W-1:0]    event_code;
   logic [NUM_KEYS-1:0] fire;
   logic [NUM_KEYS-1:0] pressed;
   logic                step;

   // accept while the output register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
      end else if (csr_wen) begin
         threshold_ff <= csr_wdata;
      end
   end

   // one debounce lane per key; keys without a line read as released
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      if (k < LINE_BITS) begin : g_line
         assign pressed[k] = !req_tdata[k];
      end else begin : g_noline
         assign pressed[k] = 1'b0;
      end

      mkcd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .pressed   (pressed[k]),
         .threshold (threshold_ff),
         .fire      (fire[k])
      );
   end

   // merge lane results into the event code
   mkcd_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .fire       (fire),
      .event_code (event_code)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (step) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_event_ff <= event_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_event_ff);

   // no sample is taken while a stalled event word is held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !step)
      else $error("sample accepted over a stalled event word");

   // every accepted sample yields an event word on the next cycle
   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted sample produced no event word");

   // only keys with a line can raise an event
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_event_ff <= EVT_W'(LINE_BITS)))
      else $error("event code names a key without a line");

endmodule

>>> rtl/mkcd_lane.sv
// ----------------------------------------------------------------------------
// mkcd_lane
// Per-key up/down debounce counter with a handled flag and press detection.
// ----------------------------------------------------------------------------
module mkcd_lane
   import mkcd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,       // one sample word accepted this cycle
   input  logic             pressed,    // key line sampled low
   input  logic [CNT_W-1:0] threshold,
   output logic             fire        // press recognized on this sample
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             handled_ff;
   logic             handled_in;
   logic [CNT_W-1:0] count_up;
   logic [CNT_W-1:0] count_dn;

   assign count_up = count_ff + CNT_W'(1);
   assign count_dn = count_ff - CNT_W'(1);

   // counter and flag update for one sample
   always_comb begin
      count_in   = count_ff;
      handled_in = handled_ff;
      fire       = 1'b0;
      if (step) begin
         if (pressed) begin
            if ((count_ff < threshold) && !handled_ff) begin
               count_in = count_up;
               if (count_up == threshold) begin
                  handled_in = 1'b1;
                  fire       = 1'b1;
               end
            end
         end else if (count_ff != '0) begin
            count_in = count_dn;
            if (count_dn == '0) begin
               handled_in = 1'b0;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         handled_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         handled_ff <= handled_in;
      end
   end

   // a handled key always has a nonzero count
   a_handled_nonzero: assert property (@(posedge clock) disable iff (reset)
      handled_ff |-> (count_ff != '0))
      else $error("handled flag set with zero count");

   // counter moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((count_ff == $past(count_ff)) ||
                         (count_ff == $past(count_ff) + CNT_W'(1)) ||
                         (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("counter jumped by more than one");

   // a press fires only on an accepted sample of a pressed key
   a_fire_cause: assert property (@(posedge clock) disable iff (reset)
      fire |-> (step && pressed && !handled_ff))
      else $error("press event without a pressed, unhandled key");

endmodule

>>> rtl/mkcd_merge.sv
// ----------------------------------------------------------------------------
// mkcd_merge
// Combines the lane press flags into one event code, highest key wins.
// ----------------------------------------------------------------------------
module mkcd_merge
   import mkcd_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
   input  logic [NUM_KEYS-1:0] fire,
   output logic [EVT_W-1:0]    event_code
);

   // later (higher) keys override earlier ones; code is index plus one
   always_comb begin
      event_code = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (fire[k]) begin
            event_code = EVT_W'(k + 1);
         end
      end
   end

endmodule

>>> tb/multi_key_counter_debouncer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_key_counter_debouncer_top_tb
// Streams key sample words through the debouncer and checks every press event
// word against a per-key counter model kept in step with each accepted sample,
// across several press thresholds, random idling and a long output stall.
// ----------------------------------------------------------------------------
module multi_key_counter_debouncer_top_tb
   import mkcd_pkg::*;
();

   localparam int NUM_KEYS     = NUM_KEYS_DEF;
   localparam int IDLE_PCT     = 14;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 60;
   localparam int TIMEOUT_NS   = 200_000;

   typedef logic [CNT_W-1:0]     count_type;
   typedef logic [EVT_W-1:0]     event_type;
   typedef logic [LINE_BITS-1:0] levels_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [3:0] key_levels_n
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [2:0] press_event
   logic                   csr_wen    = 1'b0;
   logic [CNT_W-1:0]       csr_wdata  = '0;

   bit idle_on     = 1'b1;
   int hold_cycles = 0;
   int error_count = 0;

   // debounce model state
   count_type model_threshold;
   count_type key_count [NUM_KEYS];
   logic      key_handled [NUM_KEYS];
   event_type pending_events [$];

   multi_key_counter_debouncer_top #(
      .NUM_KEYS (NUM_KEYS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("multi_key_counter_debouncer_top: mismatch");
      $finish;
   end

   task automatic report_mismatch(string what);
      $display("%0t ns: %s", $time, what);
      error_count++;
   endtask

   // one sample through all key lanes, returns the event code
   function automatic event_type debounce_sample(levels_type levels_n);
      event_type code;
      logic      pressed;
      int        k;
      code = '0;
      for (k = 0; k < NUM_KEYS; k++) begin
         pressed = (k < LINE_BITS) ? ~levels_n[k] : 1'b0;
         if (pressed) begin
            // counts up only while below threshold and not yet handled
            if (key_count[k] < model_threshold && !key_handled[k]) begin
               key_count[k] = key_count[k] + 1'b1;
               if (key_count[k] == model_threshold) begin
                  key_handled[k] = 1'b1;
                  code = event_type'(k + 1);
               end
            end
         end else if (key_count[k] != '0) begin
            key_count[k] = key_count[k] - 1'b1;
            if (key_count[k] == '0)
               key_handled[k] = 1'b0;
         end
      end
      return code;
   endfunction

   // track threshold writes and accepted sample words
   always @(posedge clock) begin
      if (reset) begin
         model_threshold = THRESHOLD_RST;
         foreach (key_count[k]) begin
            key_count[k]   = '0;
            key_handled[k] = 1'b0;
         end
      end else begin
         if (csr_wen)
            model_threshold = csr_wdata;
         if (req_tvalid && req_tready)
            pending_events.push_back(debounce_sample(req_tdata[LINE_BITS-1:0]));
      end
   end

   // check each event word against the oldest pending event
   always @(posedge clock) begin
      event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("event word %0h with nothing pending", rsp_tdata));
         end else begin
            want = pending_events.pop_front();
            if (rsp_tdata !== RSP_TDATA_W'(want))
               report_mismatch($sformatf("event word %0h, expected %0h", rsp_tdata, want));
         end
      end
   end

   // event sink: random stalls, plus a counted hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (idle_on) begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // offer one sample word and wait for it to be taken
   task automatic send_word(levels_type levels_n);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(levels_n);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_run(levels_type levels_n, int count);
      repeat (count) send_word(levels_n);
   endtask

   // stop offering and let every pending event come out
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(count_type value);
      settle();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // threshold after reset, key 3 held until it fires
   task automatic test_default_threshold();
      send_run(4'h7, 16);
      send_run(4'hf, 2);
   endtask

   // simultaneous fire, handled hold, release clearing, lowered threshold
   task automatic test_directed_cases();
      write_threshold(8'd2);
      send_run(4'hf, 1);
      send_run(4'h0, 3);
      send_run(4'hf, 2);
      send_run(4'he, 2);
      send_run(4'h5, 2);
      send_run(4'ha, 2);
      send_run(4'hf, 3);
      // key 1 partway up, then threshold dropped under its count
      write_threshold(8'd3);
      send_run(4'hd, 2);
      write_threshold(8'd1);
      send_run(4'hd, 1);
      send_run(4'hf, 2);
      send_run(4'hd, 1);
   endtask

   // zero threshold never fires, release still counts down
   task automatic test_threshold_zero();
      write_threshold(8'd0);
      send_run(4'h0, 3);
      send_run(4'hf, 2);
      send_run(4'h0, 1);
   endtask

   // largest threshold, all keys held long enough to fire together
   task automatic test_threshold_max();
      write_threshold(8'hff);
      send_run(4'h0, 256);
      send_run(4'h6, 4);
   endtask

   // held patterns with occasional bounce, plus pure noise runs
   task automatic test_random_debounce(count_type threshold, int n_items);
      levels_type base;
      levels_type levels;
      int         run_len;
      int         sent;
      int         bit_sel;
      bit         noisy;
      write_threshold(threshold);
      sent = 0;
      while (sent < n_items) begin
         base    = levels_type'($urandom_range(0, 15));
         run_len = $urandom_range(1, 2 * int'(threshold) + 4);
         noisy   = ($urandom_range(0, 5) == 0);
         repeat (run_len) begin
            if (noisy) begin
               levels = levels_type'($urandom_range(0, 15));
            end else begin
               levels = base;
               if ($urandom_range(0, 7) == 0) begin
                  bit_sel = $urandom_range(0, LINE_BITS - 1);
                  levels[bit_sel] = ~levels[bit_sel];
               end
            end
            send_word(levels);
            sent++;
         end
      end
   endtask

   // sink holds off while samples keep coming, so the input stalls
   task automatic test_backpressure();
      write_threshold(8'd1);
      idle_on     = 1'b0;
      hold_cycles = HOLD_CYCLES;
      repeat (40) send_word(levels_type'($urandom_range(0, 15)));
      settle();
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_threshold();
      test_directed_cases();
      test_threshold_zero();
      test_threshold_max();
      test_random_debounce(8'd1, 160);
      test_random_debounce(8'd2, 160);
      test_random_debounce(8'd3, 160);
      test_random_debounce(8'd5, 160);
      test_backpressure();
      // a long stretch with both sides streaming freely
      idle_on = 1'b0;
      test_random_debounce(8'd4, 160);
      idle_on = 1'b1;
      test_random_debounce(count_type'($urandom_range(1, 8)), 120);
      settle();
      if (error_count == 0)
         $display("multi_key_counter_debouncer_top: match");
      else
         $display("multi_key_counter_debouncer_top: mismatch");
      $finish;
   end

endmodule
